// File: rtl/core/lut_colormap_interpolator_assert.svh
// Assertion helpers for the colormap interpolator.
`ifndef LUT_COLORMAP_INTERPOLATOR_ASSERT_SVH
`define LUT_COLORMAP_INTERPOLATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LCMI_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lcmi assertion failed");
`define LCMI_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("lcmi assertion failed");
`else
`define LCMI_ASSERT(name, clk, rst, prop)
`define LCMI_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// File: rtl/core/lcmi_pkg.sv
`default_nettype none
package lcmi_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = 8;
  localparam int WEIGHT_BITS   = 10;
  localparam int COLOR_W       = 8;
  localparam int RGB_W         = 3 * COLOR_W;
  localparam int SAMPLE_W      = 32;
  localparam int SCALE_W       = 48;
  localparam int SCALE_HALF_W  = SCALE_W / 2;
  localparam int PART_W        = SAMPLE_W + SCALE_HALF_W;
  localparam int PROD_W        = SAMPLE_W + SCALE_W;
  localparam int POS_W         = 24;
  localparam int FRAC_W        = 16;
  localparam int LIMIT_BIT     = POS_W + FRAC_W;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 48;

  localparam logic [POS_W-1:0] HALF_BIN = POS_W'(32'h8000);
  localparam logic [WEIGHT_BITS:0] ONE_WEIGHT = {1'b1, {WEIGHT_BITS{1'b0}}};

  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_VALUE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BIN_SCALE  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAP_SELECT = 2'd2;

  typedef struct packed {
    logic                   black;
    logic                   last;
    logic [IDX_W-1:0]       left;
    logic [WEIGHT_BITS:0]   fr;
  } pos_t;

  typedef struct packed {
    logic                   black;
    logic                   last;
    logic [WEIGHT_BITS:0]   fr;
    logic [RGB_W-1:0]       left_rgb;
    logic [RGB_W-1:0]       right_rgb;
  } mix_t;

  localparam logic [RGB_W-1:0] TURBO_LUT [TABLE_ENTRIES] = '{
    {8'd48,8'd18,8'd59}, {8'd50,8'd21,8'd67}, {8'd51,8'd24,8'd74}, {8'd52,8'd27,8'd81},
    {8'd53,8'd30,8'd88}, {8'd54,8'd33,8'd95}, {8'd55,8'd36,8'd102}, {8'd56,8'd39,8'd109},
    {8'd57,8'd42,8'd115}, {8'd58,8'd45,8'd121}, {8'd59,8'd47,8'd128}, {8'd60,8'd50,8'd134},
    {8'd61,8'd53,8'd139}, {8'd62,8'd56,8'd145}, {8'd63,8'd59,8'd151}, {8'd63,8'd62,8'd156},
    {8'd64,8'd64,8'd162}, {8'd65,8'd67,8'd167}, {8'd65,8'd70,8'd172}, {8'd66,8'd73,8'd177},
    {8'd66,8'd75,8'd181}, {8'd67,8'd78,8'd186}, {8'd68,8'd81,8'd191}, {8'd68,8'd84,8'd195},
    {8'd68,8'd86,8'd199}, {8'd69,8'd89,8'd203}, {8'd69,8'd92,8'd207}, {8'd69,8'd94,8'd211},
    {8'd70,8'd97,8'd214}, {8'd70,8'd100,8'd218}, {8'd70,8'd102,8'd221}, {8'd70,8'd105,8'd224},
    {8'd70,8'd107,8'd227}, {8'd71,8'd110,8'd230}, {8'd71,8'd113,8'd233}, {8'd71,8'd115,8'd235},
    {8'd71,8'd118,8'd238}, {8'd71,8'd120,8'd240}, {8'd71,8'd123,8'd242}, {8'd70,8'd125,8'd244},
    {8'd70,8'd128,8'd246}, {8'd70,8'd130,8'd248}, {8'd70,8'd133,8'd250}, {8'd70,8'd135,8'd251},
    {8'd69,8'd138,8'd252}, {8'd69,8'd140,8'd253}, {8'd68,8'd143,8'd254}, {8'd67,8'd145,8'd254},
    {8'd66,8'd148,8'd255}, {8'd65,8'd150,8'd255}, {8'd64,8'd153,8'd255}, {8'd62,8'd155,8'd254},
    {8'd61,8'd158,8'd254}, {8'd59,8'd160,8'd253}, {8'd58,8'd163,8'd252}, {8'd56,8'd165,8'd251},
    {8'd55,8'd168,8'd250}, {8'd53,8'd171,8'd248}, {8'd51,8'd173,8'd247}, {8'd49,8'd175,8'd245},
    {8'd47,8'd178,8'd244}, {8'd46,8'd180,8'd242}, {8'd44,8'd183,8'd240}, {8'd42,8'd185,8'd238},
    {8'd40,8'd188,8'd235}, {8'd39,8'd190,8'd233}, {8'd37,8'd192,8'd231}, {8'd35,8'd195,8'd228},
    {8'd34,8'd197,8'd226}, {8'd32,8'd199,8'd223}, {8'd31,8'd201,8'd221}, {8'd30,8'd203,8'd218},
    {8'd28,8'd205,8'd216}, {8'd27,8'd208,8'd213}, {8'd26,8'd210,8'd210}, {8'd26,8'd212,8'd208},
    {8'd25,8'd213,8'd205}, {8'd24,8'd215,8'd202}, {8'd24,8'd217,8'd200}, {8'd24,8'd219,8'd197},
    {8'd24,8'd221,8'd194}, {8'd24,8'd222,8'd192}, {8'd24,8'd224,8'd189}, {8'd25,8'd226,8'd187},
    {8'd25,8'd227,8'd185}, {8'd26,8'd228,8'd182}, {8'd28,8'd230,8'd180}, {8'd29,8'd231,8'd178},
    {8'd31,8'd233,8'd175}, {8'd32,8'd234,8'd172}, {8'd34,8'd235,8'd170}, {8'd37,8'd236,8'd167},
    {8'd39,8'd238,8'd164}, {8'd42,8'd239,8'd161}, {8'd44,8'd240,8'd158}, {8'd47,8'd241,8'd155},
    {8'd50,8'd242,8'd152}, {8'd53,8'd243,8'd148}, {8'd56,8'd244,8'd145}, {8'd60,8'd245,8'd142},
    {8'd63,8'd246,8'd138}, {8'd67,8'd247,8'd135}, {8'd70,8'd248,8'd132}, {8'd74,8'd248,8'd128},
    {8'd78,8'd249,8'd125}, {8'd82,8'd250,8'd122}, {8'd85,8'd250,8'd118}, {8'd89,8'd251,8'd115},
    {8'd93,8'd252,8'd111}, {8'd97,8'd252,8'd108}, {8'd101,8'd253,8'd105}, {8'd105,8'd253,8'd102},
    {8'd109,8'd254,8'd98}, {8'd113,8'd254,8'd95}, {8'd117,8'd254,8'd92}, {8'd121,8'd254,8'd89},
    {8'd125,8'd255,8'd86}, {8'd128,8'd255,8'd83}, {8'd132,8'd255,8'd81}, {8'd136,8'd255,8'd78},
    {8'd139,8'd255,8'd75}, {8'd143,8'd255,8'd73}, {8'd146,8'd255,8'd71}, {8'd150,8'd254,8'd68},
    {8'd153,8'd254,8'd66}, {8'd156,8'd254,8'd64}, {8'd159,8'd253,8'd63}, {8'd161,8'd253,8'd61},
    {8'd164,8'd252,8'd60}, {8'd167,8'd252,8'd58}, {8'd169,8'd251,8'd57}, {8'd172,8'd251,8'd56},
    {8'd175,8'd250,8'd55}, {8'd177,8'd249,8'd54}, {8'd180,8'd248,8'd54}, {8'd183,8'd247,8'd53},
    {8'd185,8'd246,8'd53}, {8'd188,8'd245,8'd52}, {8'd190,8'd244,8'd52}, {8'd193,8'd243,8'd52},
    {8'd195,8'd241,8'd52}, {8'd198,8'd240,8'd52}, {8'd200,8'd239,8'd52}, {8'd203,8'd237,8'd52},
    {8'd205,8'd236,8'd52}, {8'd208,8'd234,8'd52}, {8'd210,8'd233,8'd53}, {8'd212,8'd231,8'd53},
    {8'd215,8'd229,8'd53}, {8'd217,8'd228,8'd54}, {8'd219,8'd226,8'd54}, {8'd221,8'd224,8'd55},
    {8'd223,8'd223,8'd55}, {8'd225,8'd221,8'd55}, {8'd227,8'd219,8'd56}, {8'd229,8'd217,8'd56},
    {8'd231,8'd215,8'd57}, {8'd233,8'd213,8'd57}, {8'd235,8'd211,8'd57}, {8'd236,8'd209,8'd58},
    {8'd238,8'd207,8'd58}, {8'd239,8'd205,8'd58}, {8'd241,8'd203,8'd58}, {8'd242,8'd201,8'd58},
    {8'd244,8'd199,8'd58}, {8'd245,8'd197,8'd58}, {8'd246,8'd195,8'd58}, {8'd247,8'd193,8'd58},
    {8'd248,8'd190,8'd57}, {8'd249,8'd188,8'd57}, {8'd250,8'd186,8'd57}, {8'd251,8'd184,8'd56},
    {8'd251,8'd182,8'd55}, {8'd252,8'd179,8'd54}, {8'd252,8'd177,8'd54}, {8'd253,8'd174,8'd53},
    {8'd253,8'd172,8'd52}, {8'd254,8'd169,8'd51}, {8'd254,8'd167,8'd50}, {8'd254,8'd164,8'd49},
    {8'd254,8'd161,8'd48}, {8'd254,8'd158,8'd47}, {8'd254,8'd155,8'd45}, {8'd254,8'd153,8'd44},
    {8'd254,8'd150,8'd43}, {8'd254,8'd147,8'd42}, {8'd254,8'd144,8'd41}, {8'd253,8'd141,8'd39},
    {8'd253,8'd138,8'd38}, {8'd252,8'd135,8'd37}, {8'd252,8'd132,8'd35}, {8'd251,8'd129,8'd34},
    {8'd251,8'd126,8'd33}, {8'd250,8'd123,8'd31}, {8'd249,8'd120,8'd30}, {8'd249,8'd117,8'd29},
    {8'd248,8'd114,8'd28}, {8'd247,8'd111,8'd26}, {8'd246,8'd108,8'd25}, {8'd245,8'd105,8'd24},
    {8'd244,8'd102,8'd23}, {8'd243,8'd99,8'd21}, {8'd242,8'd96,8'd20}, {8'd241,8'd93,8'd19},
    {8'd240,8'd91,8'd18}, {8'd239,8'd88,8'd17}, {8'd237,8'd85,8'd16}, {8'd236,8'd83,8'd15},
    {8'd235,8'd80,8'd14}, {8'd234,8'd78,8'd13}, {8'd232,8'd75,8'd12}, {8'd231,8'd73,8'd12},
    {8'd229,8'd71,8'd11}, {8'd228,8'd69,8'd10}, {8'd226,8'd67,8'd10}, {8'd225,8'd65,8'd9},
    {8'd223,8'd63,8'd8}, {8'd221,8'd61,8'd8}, {8'd220,8'd59,8'd7}, {8'd218,8'd57,8'd7},
    {8'd216,8'd55,8'd6}, {8'd214,8'd53,8'd6}, {8'd212,8'd51,8'd5}, {8'd210,8'd49,8'd5},
    {8'd208,8'd47,8'd5}, {8'd206,8'd45,8'd4}, {8'd204,8'd43,8'd4}, {8'd202,8'd42,8'd4},
    {8'd200,8'd40,8'd3}, {8'd197,8'd38,8'd3}, {8'd195,8'd37,8'd3}, {8'd193,8'd35,8'd2},
    {8'd190,8'd33,8'd2}, {8'd188,8'd32,8'd2}, {8'd185,8'd30,8'd2}, {8'd183,8'd29,8'd2},
    {8'd180,8'd27,8'd1}, {8'd178,8'd26,8'd1}, {8'd175,8'd24,8'd1}, {8'd172,8'd23,8'd1},
    {8'd169,8'd22,8'd1}, {8'd167,8'd20,8'd1}, {8'd164,8'd19,8'd1}, {8'd161,8'd18,8'd1},
    {8'd158,8'd16,8'd1}, {8'd155,8'd15,8'd1}, {8'd152,8'd14,8'd1}, {8'd149,8'd13,8'd1},
    {8'd146,8'd11,8'd1}, {8'd142,8'd10,8'd1}, {8'd139,8'd9,8'd2}, {8'd136,8'd8,8'd2},
    {8'd133,8'd7,8'd2}, {8'd129,8'd6,8'd2}, {8'd126,8'd5,8'd2}, {8'd122,8'd4,8'd3}
  };

  localparam logic [RGB_W-1:0] INFERNO_LUT [TABLE_ENTRIES] = '{
    {8'd1,8'd0,8'd4}, {8'd1,8'd0,8'd5}, {8'd1,8'd0,8'd6}, {8'd2,8'd1,8'd8},
    {8'd2,8'd1,8'd10}, {8'd3,8'd1,8'd12}, {8'd4,8'd2,8'd14}, {8'd4,8'd2,8'd16},
    {8'd5,8'd3,8'd18}, {8'd6,8'd3,8'd21}, {8'd7,8'd3,8'd23}, {8'd8,8'd4,8'd25},
    {8'd10,8'd4,8'd27}, {8'd11,8'd5,8'd29}, {8'd12,8'd5,8'd32}, {8'd14,8'd6,8'd34},
    {8'd15,8'd6,8'd36}, {8'd17,8'd7,8'd38}, {8'd18,8'd7,8'd41}, {8'd19,8'd8,8'd43},
    {8'd21,8'd8,8'd45}, {8'd22,8'd8,8'd48}, {8'd24,8'd9,8'd50}, {8'd25,8'd9,8'd53},
    {8'd27,8'd9,8'd55}, {8'd28,8'd9,8'd58}, {8'd30,8'd9,8'd60}, {8'd32,8'd9,8'd62},
    {8'd33,8'd9,8'd65}, {8'd35,8'd9,8'd67}, {8'd37,8'd9,8'd70}, {8'd39,8'd9,8'd72},
    {8'd40,8'd9,8'd74}, {8'd42,8'd8,8'd77}, {8'd44,8'd8,8'd79}, {8'd46,8'd7,8'd81},
    {8'd47,8'd7,8'd83}, {8'd49,8'd6,8'd85}, {8'd51,8'd6,8'd87}, {8'd53,8'd5,8'd89},
    {8'd55,8'd5,8'd91}, {8'd56,8'd4,8'd93}, {8'd58,8'd4,8'd94}, {8'd60,8'd3,8'd96},
    {8'd61,8'd3,8'd97}, {8'd63,8'd3,8'd98}, {8'd65,8'd2,8'd99}, {8'd66,8'd2,8'd100},
    {8'd68,8'd2,8'd102}, {8'd70,8'd2,8'd102}, {8'd71,8'd2,8'd103}, {8'd73,8'd2,8'd104},
    {8'd74,8'd2,8'd105}, {8'd76,8'd3,8'd106}, {8'd77,8'd3,8'd106}, {8'd79,8'd3,8'd107},
    {8'd80,8'd3,8'd107}, {8'd82,8'd4,8'd108}, {8'd83,8'd4,8'd108}, {8'd85,8'd5,8'd109},
    {8'd86,8'd6,8'd109}, {8'd88,8'd6,8'd109}, {8'd89,8'd7,8'd110}, {8'd91,8'd7,8'd110},
    {8'd92,8'd8,8'd110}, {8'd94,8'd9,8'd110}, {8'd95,8'd10,8'd110}, {8'd97,8'd11,8'd111},
    {8'd98,8'd11,8'd111}, {8'd99,8'd12,8'd111}, {8'd101,8'd13,8'd111}, {8'd102,8'd14,8'd111},
    {8'd104,8'd15,8'd111}, {8'd105,8'd15,8'd111}, {8'd107,8'd16,8'd111}, {8'd108,8'd17,8'd111},
    {8'd110,8'd18,8'd111}, {8'd111,8'd18,8'd111}, {8'd112,8'd19,8'd111}, {8'd114,8'd20,8'd111},
    {8'd115,8'd20,8'd111}, {8'd117,8'd21,8'd110}, {8'd118,8'd22,8'd110}, {8'd120,8'd23,8'd110},
    {8'd121,8'd23,8'd110}, {8'd123,8'd24,8'd110}, {8'd124,8'd25,8'd110}, {8'd126,8'd25,8'd109},
    {8'd127,8'd26,8'd109}, {8'd129,8'd27,8'd109}, {8'd130,8'd27,8'd108}, {8'd131,8'd28,8'd108},
    {8'd133,8'd29,8'd108}, {8'd134,8'd29,8'd108}, {8'd136,8'd30,8'd107}, {8'd137,8'd30,8'd107},
    {8'd139,8'd31,8'd106}, {8'd140,8'd32,8'd106}, {8'd142,8'd32,8'd106}, {8'd143,8'd33,8'd105},
    {8'd145,8'd34,8'd105}, {8'd146,8'd34,8'd104}, {8'd148,8'd35,8'd104}, {8'd149,8'd36,8'd103},
    {8'd151,8'd36,8'd103}, {8'd152,8'd37,8'd102}, {8'd154,8'd38,8'd102}, {8'd155,8'd38,8'd101},
    {8'd157,8'd39,8'd100}, {8'd158,8'd40,8'd100}, {8'd160,8'd40,8'd99}, {8'd161,8'd41,8'd98},
    {8'd162,8'd42,8'd98}, {8'd164,8'd42,8'd97}, {8'd165,8'd43,8'd96}, {8'd167,8'd44,8'd96},
    {8'd168,8'd44,8'd95}, {8'd170,8'd45,8'd94}, {8'd171,8'd46,8'd93}, {8'd173,8'd47,8'd93},
    {8'd174,8'd47,8'd92}, {8'd176,8'd48,8'd91}, {8'd177,8'd49,8'd90}, {8'd178,8'd50,8'd89},
    {8'd180,8'd51,8'd88}, {8'd181,8'd51,8'd88}, {8'd183,8'd52,8'd87}, {8'd184,8'd53,8'd86},
    {8'd185,8'd54,8'd85}, {8'd187,8'd55,8'd84}, {8'd188,8'd56,8'd83}, {8'd189,8'd57,8'd82},
    {8'd191,8'd57,8'd81}, {8'd192,8'd58,8'd80}, {8'd194,8'd59,8'd79}, {8'd195,8'd60,8'd78},
    {8'd196,8'd61,8'd77}, {8'd197,8'd62,8'd76}, {8'd199,8'd63,8'd75}, {8'd200,8'd64,8'd74},
    {8'd201,8'd65,8'd73}, {8'd203,8'd66,8'd72}, {8'd204,8'd67,8'd71}, {8'd205,8'd69,8'd70},
    {8'd206,8'd70,8'd69}, {8'd207,8'd71,8'd67}, {8'd209,8'd72,8'd66}, {8'd210,8'd73,8'd65},
    {8'd211,8'd74,8'd64}, {8'd212,8'd76,8'd63}, {8'd213,8'd77,8'd62}, {8'd214,8'd78,8'd61},
    {8'd215,8'd79,8'd59}, {8'd217,8'd81,8'd58}, {8'd218,8'd82,8'd57}, {8'd219,8'd83,8'd56},
    {8'd220,8'd85,8'd55}, {8'd221,8'd86,8'd54}, {8'd222,8'd87,8'd52}, {8'd223,8'd89,8'd51},
    {8'd224,8'd90,8'd50}, {8'd224,8'd92,8'd49}, {8'd225,8'd93,8'd48}, {8'd226,8'd95,8'd46},
    {8'd227,8'd96,8'd45}, {8'd228,8'd98,8'd44}, {8'd229,8'd99,8'd43}, {8'd230,8'd101,8'd41},
    {8'd230,8'd102,8'd40}, {8'd231,8'd104,8'd39}, {8'd232,8'd105,8'd37}, {8'd233,8'd107,8'd36},
    {8'd233,8'd108,8'd35}, {8'd234,8'd110,8'd34}, {8'd235,8'd112,8'd32}, {8'd235,8'd113,8'd31},
    {8'd236,8'd115,8'd29}, {8'd237,8'd117,8'd28}, {8'd237,8'd118,8'd27}, {8'd238,8'd120,8'd25},
    {8'd238,8'd122,8'd24}, {8'd239,8'd124,8'd22}, {8'd239,8'd125,8'd21}, {8'd240,8'd127,8'd19},
    {8'd240,8'd129,8'd18}, {8'd241,8'd130,8'd16}, {8'd241,8'd132,8'd15}, {8'd241,8'd134,8'd13},
    {8'd242,8'd136,8'd12}, {8'd242,8'd138,8'd10}, {8'd242,8'd139,8'd8}, {8'd243,8'd141,8'd7},
    {8'd243,8'd143,8'd6}, {8'd243,8'd145,8'd4}, {8'd244,8'd147,8'd3}, {8'd244,8'd149,8'd3},
    {8'd244,8'd150,8'd2}, {8'd244,8'd152,8'd1}, {8'd244,8'd154,8'd1}, {8'd244,8'd156,8'd1},
    {8'd244,8'd158,8'd1}, {8'd245,8'd160,8'd1}, {8'd245,8'd162,8'd2}, {8'd245,8'd164,8'd2},
    {8'd245,8'd166,8'd3}, {8'd245,8'd168,8'd5}, {8'd245,8'd169,8'd6}, {8'd244,8'd171,8'd8},
    {8'd244,8'd173,8'd10}, {8'd244,8'd175,8'd12}, {8'd244,8'd177,8'd14}, {8'd244,8'd179,8'd17},
    {8'd244,8'd181,8'd19}, {8'd244,8'd183,8'd21}, {8'd243,8'd185,8'd24}, {8'd243,8'd187,8'd26},
    {8'd243,8'd189,8'd28}, {8'd243,8'd191,8'd31}, {8'd242,8'd193,8'd33}, {8'd242,8'd195,8'd36},
    {8'd242,8'd197,8'd38}, {8'd241,8'd199,8'd41}, {8'd241,8'd201,8'd44}, {8'd240,8'd203,8'd46},
    {8'd240,8'd205,8'd49}, {8'd240,8'd207,8'd52}, {8'd239,8'd209,8'd55}, {8'd239,8'd211,8'd58},
    {8'd238,8'd213,8'd61}, {8'd238,8'd215,8'd64}, {8'd237,8'd217,8'd67}, {8'd237,8'd219,8'd70},
    {8'd236,8'd220,8'd73}, {8'd235,8'd222,8'd77}, {8'd235,8'd224,8'd80}, {8'd234,8'd226,8'd84},
    {8'd234,8'd228,8'd87}, {8'd234,8'd230,8'd91}, {8'd233,8'd232,8'd95}, {8'd233,8'd234,8'd99},
    {8'd233,8'd235,8'd103}, {8'd232,8'd237,8'd107}, {8'd232,8'd239,8'd111}, {8'd232,8'd240,8'd115},
    {8'd233,8'd242,8'd119}, {8'd233,8'd243,8'd124}, {8'd234,8'd245,8'd128}, {8'd234,8'd246,8'd132},
    {8'd235,8'd248,8'd136}, {8'd236,8'd249,8'd140}, {8'd237,8'd250,8'd144}, {8'd238,8'd251,8'd148},
    {8'd240,8'd252,8'd152}, {8'd241,8'd254,8'd156}, {8'd243,8'd255,8'd160}, {8'd245,8'd255,8'd163}
  };

endpackage
`default_nettype wire

// File: rtl/core/sample_if.sv
`default_nettype none
interface sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;
  logic               sample_invalid;
  logic               last_pixel;

  modport source (output valid, output sample, output sample_invalid, output last_pixel,
                  input ready);
  modport sink (input valid, input sample, input sample_invalid, input last_pixel,
                output ready);
endinterface
`default_nettype wire

// File: rtl/core/pixel_if.sv
`default_nettype none
interface pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_pixel_out;

  modport source (output valid, output red, output green, output blue,
                  output last_pixel_out, input ready);
  modport sink (input valid, input red, input green, input blue,
                input last_pixel_out, output ready);
endinterface
`default_nettype wire

// File: rtl/core/cfg_if.sv
`default_nettype none
interface cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [47:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/lcmi_scale.sv
`default_nettype none
`include "lut_colormap_interpolator_assert.svh"
module lcmi_scale import lcmi_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  sample_if.sink                     pixels_in,
  input  logic signed [SAMPLE_W-1:0] min_value,
  input  logic [SCALE_W-1:0]         bin_scale,
  output logic                       pos_valid,
  input  logic                       pos_ready,
  output pos_t                       pos_out
);

  localparam int FR_W = FRAC_W + WEIGHT_BITS + 1;

  // Stage A: offset from the minimum.
  logic                a_valid;
  logic [SAMPLE_W-1:0] a_diff;
  logic                a_black;
  logic                a_last;
  // Stage B: two partial products.
  logic                b_valid;
  logic [PART_W-1:0]   b_lo;
  logic [PART_W-1:0]   b_hi;
  logic                b_black;
  logic                b_last;
  // Stage C: bin position.
  logic                c_valid;
  logic [POS_W-1:0]    c_pos;
  logic                c_black;
  logic                c_last;
  // Stage D: index and weight.
  logic                d_valid;
  pos_t                d_pos;

  logic adv_a, adv_b, adv_c, adv_d;
  logic signed [SAMPLE_W:0] diff_wide;
  logic [PROD_W-1:0]        prod_sum;
  logic [POS_W-1:0]         adj;
  logic [FR_W-1:0]          fr_wide;

  assign adv_d = !d_valid || pos_ready;
  assign adv_c = !c_valid || adv_d;
  assign adv_b = !b_valid || adv_c;
  assign adv_a = !a_valid || adv_b;
  assign pixels_in.ready = adv_a;

  assign diff_wide = {pixels_in.sample[SAMPLE_W-1], pixels_in.sample}
                   - {min_value[SAMPLE_W-1], min_value};
  assign prod_sum = {{SCALE_HALF_W{1'b0}}, b_lo} + {b_hi, {SCALE_HALF_W{1'b0}}};
  assign adj = (c_pos > HALF_BIN) ? (c_pos - HALF_BIN) : '0;
  assign fr_wide = {1'b0, adj[FRAC_W-1:0], {WEIGHT_BITS{1'b0}}} + FR_W'(32'h8000);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      if (adv_a) a_valid <= pixels_in.valid;
      if (adv_b) b_valid <= a_valid;
      if (adv_c) c_valid <= b_valid;
      if (adv_d) d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_diff  <= diff_wide[SAMPLE_W-1:0];
      // A sample below the minimum is black unless the scale is zero.
      a_black <= pixels_in.sample_invalid || (diff_wide[SAMPLE_W] && (|bin_scale));
      a_last  <= pixels_in.last_pixel;
    end
    if (adv_b) begin
      b_lo    <= a_diff * bin_scale[SCALE_HALF_W-1:0];
      b_hi    <= a_diff * bin_scale[SCALE_W-1:SCALE_HALF_W];
      b_black <= a_black;
      b_last  <= a_last;
    end
    if (adv_c) begin
      c_pos   <= prod_sum[LIMIT_BIT-1:FRAC_W];
      c_black <= b_black || (|prod_sum[PROD_W-1:LIMIT_BIT]);
      c_last  <= b_last;
    end
    if (adv_d) begin
      d_pos.black <= c_black;
      d_pos.last  <= c_last;
      d_pos.left  <= adj[POS_W-1:FRAC_W];
      d_pos.fr    <= fr_wide[FR_W-1:FRAC_W];
    end
  end

  assign pos_valid = d_valid;
  assign pos_out   = d_pos;

  `LCMI_ASSERT(a_to_b_moves, clk, rst, (a_valid && adv_b) |=> b_valid)
  `LCMI_ASSERT(invalid_is_black, clk, rst, (pixels_in.valid && adv_a && pixels_in.sample_invalid) |=> (a_valid && a_black))
  `LCMI_ASSERT(stall_holds_c, clk, rst, (c_valid && !adv_c) |=> (c_valid && $stable(c_pos)))
  `LCMI_ASSERT(weight_in_range, clk, rst, d_valid |-> (d_pos.fr <= ONE_WEIGHT))

endmodule
`default_nettype wire

// File: rtl/core/lcmi_lookup.sv
`default_nettype none
module lcmi_lookup import lcmi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic pos_valid,
  output logic pos_ready,
  input  pos_t pos_in,
  input  logic map_select,
  output logic mix_valid,
  input  logic mix_ready,
  output mix_t mix_out
);

  logic             e_valid;
  mix_t             e_mix;
  logic             adv_e;
  logic [IDX_W-1:0] right_idx;

  assign adv_e = !e_valid || mix_ready;
  assign pos_ready = adv_e;
  // The right neighbor stops at the last entry.
  assign right_idx = (&pos_in.left) ? pos_in.left : pos_in.left + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv_e) begin
      e_valid <= pos_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_e) begin
      e_mix.black     <= pos_in.black;
      e_mix.last      <= pos_in.last;
      e_mix.fr        <= pos_in.fr;
      e_mix.left_rgb  <= map_select ? INFERNO_LUT[pos_in.left] : TURBO_LUT[pos_in.left];
      e_mix.right_rgb <= map_select ? INFERNO_LUT[right_idx] : TURBO_LUT[right_idx];
    end
  end

  assign mix_valid = e_valid;
  assign mix_out   = e_mix;

endmodule
`default_nettype wire

// File: rtl/core/lcmi_blend.sv
`default_nettype none
module lcmi_blend import lcmi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     mix_valid,
  output logic     mix_ready,
  input  mix_t     mix_in,
  pixel_if.source  colors_out
);

  localparam int SUM_W = COLOR_W + WEIGHT_BITS + 2;

  logic               f_valid;
  logic [RGB_W-1:0]   f_rgb;
  logic               f_last;
  logic               adv_f;
  logic [WEIGHT_BITS:0] fl;
  logic [RGB_W-1:0]   blended;
  logic [SUM_W-1:0]   sum [3];

  assign adv_f = !f_valid || colors_out.ready;
  assign mix_ready = adv_f;
  assign fl = ONE_WEIGHT - mix_in.fr;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = SUM_W'(mix_in.left_rgb[ch*COLOR_W +: COLOR_W]) * SUM_W'(fl)
              + SUM_W'(mix_in.right_rgb[ch*COLOR_W +: COLOR_W]) * SUM_W'(mix_in.fr);
      blended[ch*COLOR_W +: COLOR_W] = sum[ch][WEIGHT_BITS +: COLOR_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv_f) begin
      f_valid <= mix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_f) begin
      f_rgb  <= mix_in.black ? '0 : blended;
      f_last <= mix_in.last;
    end
  end

  assign colors_out.valid          = f_valid;
  assign colors_out.red            = f_rgb[2*COLOR_W +: COLOR_W];
  assign colors_out.green          = f_rgb[COLOR_W +: COLOR_W];
  assign colors_out.blue           = f_rgb[0 +: COLOR_W];
  assign colors_out.last_pixel_out = f_last;

endmodule
`default_nettype wire

// File: rtl/core/lut_colormap_interpolator.sv
// Throughput: one pixel per clock through six register stages; each stage
// stalls only when the stage after it holds data that cannot move.
// Reset (rst, synchronous): clears every stage valid bit and sets min_value,
// bin_scale and map_select to 0. Configuration writes are always ready.
`default_nettype none
module lut_colormap_interpolator import lcmi_pkg::*; (
  input logic     clk,
  input logic     rst,
  sample_if.sink  pixels_in,
  pixel_if.source colors_out,
  cfg_if.sink     cfg
);

  logic signed [SAMPLE_W-1:0] min_value;
  logic [SCALE_W-1:0]         bin_scale;
  logic                       map_select;

  logic pos_valid, pos_ready;
  pos_t pos;
  logic mix_valid, mix_ready;
  mix_t mix;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_value  <= '0;
      bin_scale  <= '0;
      map_select <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_MIN_VALUE:  min_value  <= cfg.data[SAMPLE_W-1:0];
        CFG_BIN_SCALE:  bin_scale  <= cfg.data[SCALE_W-1:0];
        CFG_MAP_SELECT: map_select <= cfg.data[0];
        default: ;
      endcase
    end
  end

  lcmi_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .pixels_in (pixels_in),
    .min_value (min_value),
    .bin_scale (bin_scale),
    .pos_valid (pos_valid),
    .pos_ready (pos_ready),
    .pos_out   (pos)
  );

  lcmi_lookup u_lookup (
    .clk        (clk),
    .rst        (rst),
    .pos_valid  (pos_valid),
    .pos_ready  (pos_ready),
    .pos_in     (pos),
    .map_select (map_select),
    .mix_valid  (mix_valid),
    .mix_ready  (mix_ready),
    .mix_out    (mix)
  );

  lcmi_blend u_blend (
    .clk        (clk),
    .rst        (rst),
    .mix_valid  (mix_valid),
    .mix_ready  (mix_ready),
    .mix_in     (mix),
    .colors_out (colors_out)
  );

endmodule
`default_nettype wire
